// File: hw/rtl/lpsm_pkg.sv
// lpsm_pkg: shared types, codes and helper functions for the layer priority mixer
// used by every module under hw/rtl; depends on nothing
package lpsm_pkg;

    localparam int CODE_W  = 7;
    localparam int INDEX_W = 9;
    localparam int MODE_W  = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CODE_W-1:0] SPR_OP_LOW         = 7'h70;
    localparam logic [CODE_W-1:0] SPR_OP_NORMAL_LAST = 7'h72;
    localparam logic [CODE_W-1:0] SPR_OP_HIGHLIGHT   = 7'h73;
    localparam logic [CODE_W-1:0] SPR_OP_SHADOW      = 7'h7b;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [MODE_W-1:0] mode_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_SHADOW    = 2'd0,
        MODE_NORMAL    = 2'd1,
        MODE_HIGHLIGHT = 2'd2
    } mode_code_t;

    typedef enum logic [1:0] {
        LAYER_A      = 2'd0,
        LAYER_B      = 2'd1,
        LAYER_SPRITE = 2'd2,
        LAYER_BG     = 2'd3
    } layer_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SH_ENABLE   = 2'd0,
        CFG_BG_COLOR    = 2'd1,
        CFG_DISP_ENABLE = 2'd2
    } cfg_addr_t;

    typedef struct packed {
        code_t plane_a_code;
        code_t plane_b_code;
        code_t sprite_code;
    } pixel_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] palette_index;
        logic               blank;
    } pixel_out_t;

    typedef struct packed {
        logic  shadow_highlight_enable;
        code_t background_color;
        logic  display_enable;
    } cfg_t;

    typedef struct packed {
        pixel_in_t codes;
        layer_t    back_pick;
        layer_t    front_pick;
    } dec_t;

    typedef struct packed {
        pixel_in_t codes;
        layer_t    layer;
        mode_t     mode;
    } sel_t;

    function automatic logic is_opaque(input code_t code);
        return |code[6:3];
    endfunction

    function automatic logic is_high(input code_t code);
        return is_opaque(code) & code[2];
    endfunction

endpackage

// File: hw/rtl/lpsm_decode.sv
// lpsm_decode: first stage, opacity/priority decode and plane and sprite picks
// depends on lpsm_pkg
module lpsm_decode (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  lpsm_pkg::pixel_in_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lpsm_pkg::dec_t     out_data
);

    logic           valid_reg;
    lpsm_pkg::dec_t data_reg;
    lpsm_pkg::dec_t data_next;
    logic           hi_a;
    logic           hi_b;
    logic           hi_s;
    logic           op_a;
    logic           op_b;
    logic           op_s;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        op_a = lpsm_pkg::is_opaque(in_data.plane_a_code);
        op_b = lpsm_pkg::is_opaque(in_data.plane_b_code);
        op_s = lpsm_pkg::is_opaque(in_data.sprite_code);
        hi_a = lpsm_pkg::is_high(in_data.plane_a_code);
        hi_b = lpsm_pkg::is_high(in_data.plane_b_code);
        hi_s = lpsm_pkg::is_high(in_data.sprite_code);

        data_next.codes = in_data;
        if (hi_a || (op_a && !hi_b)) begin
            data_next.back_pick = lpsm_pkg::LAYER_A;
        end else if (op_b) begin
            data_next.back_pick = lpsm_pkg::LAYER_B;
        end else begin
            data_next.back_pick = lpsm_pkg::LAYER_BG;
        end

        if (hi_s || (op_s && !hi_a && !hi_b)) begin
            data_next.front_pick = lpsm_pkg::LAYER_SPRITE;
        end else begin
            data_next.front_pick = data_next.back_pick;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/lpsm_mode.sv
// lpsm_mode: second stage, shadow/highlight mode and sprite operator handling
// depends on lpsm_pkg
module lpsm_mode (
    input  logic           aclk,
    input  logic           aresetn,
    input  lpsm_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  lpsm_pkg::dec_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output lpsm_pkg::sel_t out_data
);

    logic             valid_reg;
    lpsm_pkg::sel_t   data_reg;
    lpsm_pkg::sel_t   data_next;
    logic             base_pri;
    lpsm_pkg::code_t  spr;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        spr      = in_data.codes.sprite_code;
        base_pri = in_data.codes.plane_a_code[2] | in_data.codes.plane_b_code[2];

        data_next.codes = in_data.codes;
        data_next.layer = in_data.front_pick;
        if (!cfg.shadow_highlight_enable) begin
            data_next.mode = lpsm_pkg::MODE_NORMAL;
        end else begin
            data_next.mode = {1'b0, base_pri};
            if (in_data.front_pick == lpsm_pkg::LAYER_SPRITE) begin
                if (spr >= lpsm_pkg::SPR_OP_LOW && spr <= lpsm_pkg::SPR_OP_NORMAL_LAST) begin
                    data_next.mode = lpsm_pkg::MODE_NORMAL;
                end else if (spr == lpsm_pkg::SPR_OP_HIGHLIGHT) begin
                    data_next.layer = in_data.back_pick;
                    data_next.mode  = base_pri ? lpsm_pkg::MODE_HIGHLIGHT
                                               : lpsm_pkg::MODE_NORMAL;
                end else if (spr == lpsm_pkg::SPR_OP_SHADOW) begin
                    data_next.layer = in_data.back_pick;
                    data_next.mode  = lpsm_pkg::MODE_SHADOW;
                end else begin
                    data_next.mode = {1'b0, base_pri | spr[2]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/lpsm_compose.sv
// lpsm_compose: output stage, colour select, palette index and blanking
// depends on lpsm_pkg
module lpsm_compose (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lpsm_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lpsm_pkg::sel_t       in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lpsm_pkg::pixel_out_t out_data
);

    logic                 valid_reg;
    lpsm_pkg::pixel_out_t data_reg;
    lpsm_pkg::pixel_out_t data_next;
    lpsm_pkg::code_t      color;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        case (in_data.layer)
            lpsm_pkg::LAYER_A:      color = in_data.codes.plane_a_code;
            lpsm_pkg::LAYER_B:      color = in_data.codes.plane_b_code;
            lpsm_pkg::LAYER_SPRITE: color = in_data.codes.sprite_code;
            default:                color = cfg.background_color;
        endcase

        if (!cfg.display_enable) begin
            data_next.palette_index = '0;
            data_next.blank         = 1'b1;
        end else begin
            data_next.palette_index = {in_data.mode, color};
            data_next.blank         = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/layer_priority_shadow_mixer.sv
// layer_priority_shadow_mixer: top level, config registers and three-stage mixer pipeline
// depends on lpsm_pkg, lpsm_decode, lpsm_mode, lpsm_compose
// path: the decode, mode and compose stage registers lie in turn between an input and its result transaction
// throughput: one pixel per cycle while m_ready is high; each stage holds one pixel and stalls only when full
// reset: synchronous active-low aresetn clears all stage valid bits and the config registers
module layer_priority_shadow_mixer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  lpsm_pkg::pixel_in_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lpsm_pkg::pixel_out_t              m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpsm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lpsm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    lpsm_pkg::cfg_t cfg_reg;
    lpsm_pkg::cfg_t cfg_next;
    logic           dec_valid;
    logic           dec_ready;
    lpsm_pkg::dec_t dec_data;
    logic           sel_valid;
    logic           sel_ready;
    lpsm_pkg::sel_t sel_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                lpsm_pkg::CFG_SH_ENABLE:   cfg_next.shadow_highlight_enable = cfg_wdata[0];
                lpsm_pkg::CFG_BG_COLOR:    cfg_next.background_color = cfg_wdata;
                lpsm_pkg::CFG_DISP_ENABLE: cfg_next.display_enable = cfg_wdata[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lpsm_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    lpsm_mode u_mode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (sel_valid),
        .out_ready (sel_ready),
        .out_data  (sel_data)
    );

    lpsm_compose u_compose (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .in_data   (sel_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// File: hw/rtl/lpsm_checker.sv
// lpsm_checker: port-level assertions for the mixer, bound to the top level
// depends on lpsm_pkg and layer_priority_shadow_mixer
module lpsm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input lpsm_pkg::pixel_out_t              m_data
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // blanked pixels carry index zero
    a_blank_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.blank |-> m_data.palette_index == '0)
        else $error("blank pixel with nonzero index");

    // mode field never exceeds highlight
    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.palette_index[8:7] <= lpsm_pkg::MODE_HIGHLIGHT)
        else $error("palette index out of range");

    // an empty output stage means the pipeline can take input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind layer_priority_shadow_mixer lpsm_checker u_lpsm_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for layer_priority_shadow_mixer (directed and random pixels)
// a queue-fed driver, a randomly stalling receiver and a predictor kept in step with the
// register writes; depends on lpsm_pkg and layer_priority_shadow_mixer
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOWN_FAULTS = 10;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    lpsm_pkg::pixel_in_t  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    lpsm_pkg::pixel_out_t m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [lpsm_pkg::CFG_ADDR_W-1:0] cfg_addr = lpsm_pkg::CFG_SH_ENABLE;
    logic [lpsm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    lpsm_pkg::pixel_in_t  pending_pixels[$];
    lpsm_pkg::pixel_out_t mixed_pixels[$];

    logic            cur_sh_enable = 1'b0;
    lpsm_pkg::code_t cur_bg_color = '0;
    logic            cur_disp_enable = 1'b0;

    logic s_taken = 1'b0;
    int   sender_idle_pct = 15;
    int   receiver_idle_pct = 87;
    int   cycle_count = 0;
    int   fault_count = 0;
    int   pixels_sent = 0;
    int   pixels_in = 0;
    int   pixels_out = 0;
    int   blanked_out = 0;
    int   reg_writes = 0;

    layer_priority_shadow_mixer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic code_shows(lpsm_pkg::code_t c);
        return |c[6:3];
    endfunction

    function automatic logic code_on_top(lpsm_pkg::code_t c);
        return (|c[6:3]) & c[2];
    endfunction

    function automatic lpsm_pkg::pixel_out_t mix_pixel(lpsm_pkg::pixel_in_t px, logic sh_on,
                                                       lpsm_pkg::code_t bg, logic disp_on);
        lpsm_pkg::code_t      a;
        lpsm_pkg::code_t      b;
        lpsm_pkg::code_t      s;
        lpsm_pkg::layer_t     back;
        lpsm_pkg::layer_t     shown;
        lpsm_pkg::mode_code_t mode;
        lpsm_pkg::code_t      color;
        lpsm_pkg::pixel_out_t r;
        a = px.plane_a_code;
        b = px.plane_b_code;
        s = px.sprite_code;
        r.palette_index = '0;
        r.blank = 1'b1;
        if (!disp_on) return r;
        if (code_on_top(a) || (code_shows(a) && !code_on_top(b))) back = lpsm_pkg::LAYER_A;
        else if (code_shows(b)) back = lpsm_pkg::LAYER_B;
        else back = lpsm_pkg::LAYER_BG;
        if (code_on_top(s) || (code_shows(s) && !code_on_top(a) && !code_on_top(b)))
            shown = lpsm_pkg::LAYER_SPRITE;
        else
            shown = back;
        mode = lpsm_pkg::MODE_NORMAL;
        if (sh_on) begin
            mode = (a[2] | b[2]) ? lpsm_pkg::MODE_NORMAL : lpsm_pkg::MODE_SHADOW;
            if (shown == lpsm_pkg::LAYER_SPRITE) begin
                if (s >= lpsm_pkg::SPR_OP_LOW && s <= lpsm_pkg::SPR_OP_NORMAL_LAST) begin
                    mode = lpsm_pkg::MODE_NORMAL;
                end else if (s == lpsm_pkg::SPR_OP_HIGHLIGHT) begin
                    shown = back;
                    mode = (mode == lpsm_pkg::MODE_SHADOW) ? lpsm_pkg::MODE_NORMAL
                                                           : lpsm_pkg::MODE_HIGHLIGHT;
                end else if (s == lpsm_pkg::SPR_OP_SHADOW) begin
                    shown = back;
                    mode = lpsm_pkg::MODE_SHADOW;
                end else if (s[2]) begin
                    mode = lpsm_pkg::MODE_NORMAL;
                end
            end
        end
        case (shown)
            lpsm_pkg::LAYER_A:      color = a;
            lpsm_pkg::LAYER_B:      color = b;
            lpsm_pkg::LAYER_SPRITE: color = s;
            default:                color = bg;
        endcase
        r.palette_index = {mode, color};
        r.blank = 1'b0;
        return r;
    endfunction

    function automatic lpsm_pkg::code_t rand_layer(logic sprite);
        int unsigned     roll;
        lpsm_pkg::code_t c;
        roll = $urandom_range(99);
        c = lpsm_pkg::code_t'($urandom_range(127));
        if (sprite && roll < 25) begin
            case ($urandom_range(4))
                0:       c = lpsm_pkg::SPR_OP_LOW;
                1:       c = lpsm_pkg::SPR_OP_LOW + lpsm_pkg::code_t'(1);
                2:       c = lpsm_pkg::SPR_OP_NORMAL_LAST;
                3:       c = lpsm_pkg::SPR_OP_HIGHLIGHT;
                default: c = lpsm_pkg::SPR_OP_SHADOW;
            endcase
        end else if (roll < 45) begin
            c[6:3] = 4'd0;
        end
        return c;
    endfunction

    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    task automatic queue_pixel(lpsm_pkg::code_t a, lpsm_pkg::code_t b, lpsm_pkg::code_t s);
        lpsm_pkg::pixel_in_t px;
        px.plane_a_code = a;
        px.plane_b_code = b;
        px.sprite_code = s;
        pending_pixels.push_back(px);
    endtask

    task automatic write_reg(lpsm_pkg::cfg_addr_t idx, logic [lpsm_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one-bit registers get junk in the unused upper bits
    task automatic set_mixer(logic sh_on, lpsm_pkg::code_t bg, logic disp_on);
        write_reg(lpsm_pkg::CFG_SH_ENABLE, {6'($urandom_range(63)), sh_on});
        write_reg(lpsm_pkg::CFG_BG_COLOR, bg);
        write_reg(lpsm_pkg::CFG_DISP_ENABLE, {6'($urandom_range(63)), disp_on});
    endtask

    task automatic drain_mixer();
        while (pending_pixels.size() != 0 || pixels_out != pixels_sent)
            @(negedge aclk);
    endtask

    // driver: a new transaction only once the current one is taken
    always @(negedge aclk) begin : drive_pixels
        logic                next_valid;
        lpsm_pkg::pixel_in_t next_data;
        next_valid = s_valid;
        next_data = s_data;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else if (!s_valid || s_taken) begin
            next_valid = 1'b0;
            if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_valid = 1'b1;
                next_data = pending_pixels.pop_front();
                pixels_sent++;
            end
        end
        s_valid <= next_valid;
        s_data <= next_data;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge aclk) begin : watch_ports
        lpsm_pkg::pixel_out_t want;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                mixed_pixels.push_back(mix_pixel(s_data, cur_sh_enable, cur_bg_color,
                                                 cur_disp_enable));
                pixels_in++;
            end
            if (cfg_valid && cfg_ready) begin
                reg_writes++;
                case (cfg_addr)
                    lpsm_pkg::CFG_SH_ENABLE:   cur_sh_enable = cfg_wdata[0];
                    lpsm_pkg::CFG_BG_COLOR:    cur_bg_color = cfg_wdata;
                    lpsm_pkg::CFG_DISP_ENABLE: cur_disp_enable = cfg_wdata[0];
                    default:                   ;
                endcase
            end
            if (m_valid && m_ready) begin
                pixels_out++;
                if (m_data.blank) blanked_out++;
                if (mixed_pixels.size() == 0) begin
                    note_fault($sformatf("result transaction %0d with nothing pending",
                                         pixels_out));
                end else begin
                    want = mixed_pixels.pop_front();
                    if (m_data.palette_index !== want.palette_index)
                        note_fault($sformatf("result %0d palette_index exp %0d got %0d",
                                             pixels_out, want.palette_index,
                                             m_data.palette_index));
                    if (m_data.blank !== want.blank)
                        note_fault($sformatf("result %0d blank exp %0b got %0b",
                                             pixels_out, want.blank, m_data.blank));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     mixed_pixels.size());
            $display("layer_priority_shadow_mixer: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // registers at reset: display off
        queue_pixel(7'h00, 7'h00, 7'h00);
        queue_pixel(7'h7f, 7'h7f, 7'h7f);
        drain_mixer();

        set_mixer(1'b1, 7'h7f, 1'b1);
        queue_pixel(7'h00, 7'h00, 7'h00);
        queue_pixel(7'h7f, 7'h7f, 7'h7f);
        queue_pixel(7'h08, 7'h0c, 7'h00);
        queue_pixel(7'h0c, 7'h0c, 7'h00);
        queue_pixel(7'h08, 7'h10, 7'h00);
        queue_pixel(7'h08, 7'h00, 7'h10);
        queue_pixel(7'h00, 7'h0c, 7'h10);
        queue_pixel(7'h0c, 7'h00, 7'h14);
        queue_pixel(7'h04, 7'h00, 7'h00);
        queue_pixel(7'h08, 7'h00, lpsm_pkg::SPR_OP_LOW);
        queue_pixel(7'h08, 7'h00, lpsm_pkg::SPR_OP_LOW + lpsm_pkg::code_t'(1));
        queue_pixel(7'h08, 7'h00, lpsm_pkg::SPR_OP_NORMAL_LAST);
        queue_pixel(7'h08, 7'h00, lpsm_pkg::SPR_OP_HIGHLIGHT);
        queue_pixel(7'h04, 7'h08, lpsm_pkg::SPR_OP_HIGHLIGHT);
        queue_pixel(7'h00, 7'h00, lpsm_pkg::SPR_OP_HIGHLIGHT);
        queue_pixel(7'h04, 7'h08, lpsm_pkg::SPR_OP_SHADOW);
        queue_pixel(7'h0c, 7'h00, lpsm_pkg::SPR_OP_HIGHLIGHT);
        drain_mixer();

        set_mixer(1'b0, 7'h2a, 1'b1);
        queue_pixel(7'h00, 7'h00, 7'h00);
        queue_pixel(7'h04, 7'h08, lpsm_pkg::SPR_OP_HIGHLIGHT);
        queue_pixel(7'h04, 7'h08, lpsm_pkg::SPR_OP_SHADOW);
        queue_pixel(7'h08, 7'h0c, 7'h14);
        drain_mixer();

        for (int seg = 0; seg < 8; seg++) begin
            if (seg == 3) begin
                sender_idle_pct = 87;
                receiver_idle_pct = 15;
            end
            if (seg == 6) begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            case (seg)
                0:       set_mixer(1'b1, 7'h00, 1'b1);
                1:       set_mixer(1'b1, 7'h7f, 1'b1);
                2:       set_mixer(1'b0, lpsm_pkg::code_t'($urandom_range(127)), 1'b1);
                3:       set_mixer(1'b1, lpsm_pkg::code_t'($urandom_range(127)), 1'b0);
                4:       set_mixer(1'b0, 7'h7f, 1'b1);
                5:       set_mixer(1'b1, lpsm_pkg::code_t'($urandom_range(127)), 1'b1);
                6:       set_mixer(1'b0, 7'h00, 1'b1);
                default: set_mixer(1'b1, lpsm_pkg::code_t'($urandom_range(127)), 1'b1);
            endcase
            for (int n = 0; n < 100; n++) begin
                queue_pixel(rand_layer(1'b0), rand_layer(1'b0), rand_layer(1'b1));
                // hold the sender until the pipeline is empty
                if (seg == 4 && n == 49) drain_mixer();
            end
            drain_mixer();
        end

        repeat (8) @(posedge aclk);
        if (mixed_pixels.size() != 0)
            note_fault($sformatf("%0d results never arrived", mixed_pixels.size()));
        $display("%0d pixels mixed, %0d blanked, %0d register writes, three idle patterns",
                 pixels_in, blanked_out, reg_writes);
        $display("%0d faults seen over %0d cycles", fault_count, cycle_count);
        if (fault_count == 0) begin
            $display("layer_priority_shadow_mixer: match");
        end else begin
            $display("layer_priority_shadow_mixer: mismatch");
        end
        $finish;
    end

endmodule

// File: layer_priority_shadow_mixer.f
hw/rtl/lpsm_pkg.sv
hw/rtl/lpsm_decode.sv
hw/rtl/lpsm_mode.sv
hw/rtl/lpsm_compose.sv
hw/rtl/layer_priority_shadow_mixer.sv
hw/rtl/lpsm_checker.sv
tb/tb_top.sv
